FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clock edge, ignored while reset is low.
`define CTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising clock edge, reset included.
`define CTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ctd_pkg.sv
`default_nettype none
package ctd_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;

    localparam int CHROMA_W = 8;
    localparam int LIM_W    = CHROMA_W + 1;
    localparam int DIST_W   = 16;
    localparam int COL_W    = $clog2(FRAME_WIDTH);
    localparam int ROW_W    = $clog2(FRAME_HEIGHT);
    localparam int CNT_W    = 18;
    localparam int SUM_W    = 27;
    localparam int OFFX_W   = 10;
    localparam int OFFY_W   = 9;
    localparam int ANG_W    = 16;
    localparam int ANG_SHIFT = ANG_W - 1;

    localparam int PRESENT_MIN = (FRAME_WIDTH * FRAME_HEIGHT) / 256;
    localparam int HALF_W      = FRAME_WIDTH / 2;
    localparam int HALF_H      = FRAME_HEIGHT / 2;

    localparam int OFFX_MIN = -(2 ** (OFFX_W - 1));
    localparam int OFFX_MAX = (2 ** (OFFX_W - 1)) - 1;
    localparam int OFFY_MIN = -(2 ** (OFFY_W - 1));
    localparam int OFFY_MAX = (2 ** (OFFY_W - 1)) - 1;

    localparam logic [ANG_W-1:0] ANG_POS_SAT = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic [ANG_W-1:0] ANG_NEG_SAT = {1'b1, {(ANG_W-1){1'b0}}};

    localparam int DIV_N_W   = SUM_W;
    localparam int DIV_D_W   = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIST_W;

    localparam logic [LIM_W-1:0]  U_LIMIT_RST = LIM_W'(140);
    localparam logic [LIM_W-1:0]  V_LIMIT_RST = LIM_W'(100);
    localparam logic [DIST_W-1:0] DIST_RST    = DIST_W'(600);

    localparam int IN_TDATA_W   = 2 * CHROMA_W;
    localparam int OUT_FIELDS_W = OFFX_W + OFFY_W + 2 * ANG_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_U_LIMIT    = 2'd0,
        CFG_V_LIMIT    = 2'd1,
        CFG_X_DISTANCE = 2'd2,
        CFG_Y_DISTANCE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
    } t_frame_sum;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic                     present;
        logic signed [OFFX_W-1:0] offset_x;
        logic signed [OFFY_W-1:0] offset_y;
        logic [ANG_W-1:0]         angle_x;
        logic [ANG_W-1:0]         angle_y;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUO_X,
        ST_QUO_Y,
        ST_ANG_X,
        ST_ANG_Y,
        ST_SEND
    } t_back_state;

endpackage
`default_nettype wire

FILE: design/ctd_front.sv
`default_nettype none
module ctd_front import ctd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [LIM_W-1:0]    i_u_limit,
    input  wire logic [LIM_W-1:0]    i_v_limit,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CHROMA_W-1:0] i_chroma_u,
    input  wire logic [CHROMA_W-1:0] i_chroma_v,
    input  wire logic                i_frame_last,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output t_frame_sum               o_q_data
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_count, n_count, w_count;
    logic [SUM_W-1:0] r_sum_x, n_sum_x, w_sum_x;
    logic [SUM_W-1:0] r_sum_y, n_sum_y, w_sum_y;

    logic             w_accept;
    logic             w_match;
    logic [CNT_W:0]   w_cnt_add;
    logic [SUM_W:0]   w_sx_add;
    logic [SUM_W:0]   w_sy_add;
    logic [COL_W:0]   w_col_add;
    logic [ROW_W:0]   w_row_add;

    always_comb begin
        o_ready  = !i_q_full;
        w_accept = i_valid && !i_q_full;
        w_match  = (LIM_W'(i_chroma_u) < i_u_limit) && (LIM_W'(i_chroma_v) < i_v_limit);

        w_cnt_add = {1'b0, r_count} + (CNT_W+1)'(1);
        w_sx_add  = {1'b0, r_sum_x} + (SUM_W+1)'(r_col);
        w_sy_add  = {1'b0, r_sum_y} + (SUM_W+1)'(r_row);

        w_count = r_count;
        w_sum_x = r_sum_x;
        w_sum_y = r_sum_y;
        if (w_match) begin
            w_count = w_cnt_add[CNT_W] ? '1 : w_cnt_add[CNT_W-1:0];
            w_sum_x = w_sx_add[SUM_W]  ? '1 : w_sx_add[SUM_W-1:0];
            w_sum_y = w_sy_add[SUM_W]  ? '1 : w_sy_add[SUM_W-1:0];
        end

        w_col_add = (COL_W+1)'(r_col) + (COL_W+1)'(2);
        w_row_add = (ROW_W+1)'(r_row) + (ROW_W+1)'(1);

        if (i_frame_last) begin
            n_col   = '0;
            n_row   = '0;
            n_count = '0;
            n_sum_x = '0;
            n_sum_y = '0;
        end else begin
            n_count = w_count;
            n_sum_x = w_sum_x;
            n_sum_y = w_sum_y;
            if (w_col_add >= (COL_W+1)'(FRAME_WIDTH)) begin
                n_col = '0;
                n_row = (w_row_add >= (ROW_W+1)'(FRAME_HEIGHT)) ? '0 : w_row_add[ROW_W-1:0];
            end else begin
                n_col = w_col_add[COL_W-1:0];
                n_row = r_row;
            end
        end

        o_q_push       = w_accept && i_frame_last;
        o_q_data.count = w_count;
        o_q_data.sum_x = w_sum_x;
        o_q_data.sum_y = w_sum_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (w_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_count <= n_count;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
    end

endmodule
`default_nettype wire

FILE: design/ctd_queue.sv
`default_nettype none
module ctd_queue import ctd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_frame_sum i_push_data,
    output logic            o_full,
    input  wire logic       i_pop,
    output t_frame_sum      o_head,
    output logic            o_empty
);

    t_frame_sum        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_fill, n_fill;

    always_comb begin
        o_full   = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
        o_empty  = (r_fill == '0);
        o_head   = r_mem[r_rd_ptr];
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        unique case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + (QPTR_W+1)'(1);
            2'b01:   n_fill = r_fill - (QPTR_W+1)'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule
`default_nettype wire

FILE: design/ctd_div.sv
`default_nettype none
module ctd_div import ctd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DIV_D_W-1:0]   r_rem, n_rem;
    logic [DIV_N_W-1:0]   r_quo, n_quo;
    logic [DIV_D_W-1:0]   r_dvsr, n_dvsr;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    logic [DIV_D_W:0]     w_trial;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_N_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvsr});
        w_diff  = w_trial - {1'b0, r_dvsr};

        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvsr = r_dvsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvsr = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            n_quo = {r_quo[DIV_N_W-2:0], w_ge};
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end

        o_rsp.done     = r_done;
        o_rsp.quotient = r_quo;
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvsr <= n_dvsr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

endmodule
`default_nettype wire

FILE: design/ctd_back.sv
`default_nettype none
module ctd_back import ctd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [DIST_W-1:0] i_x_distance,
    input  wire logic [DIST_W-1:0] i_y_distance,
    input  wire logic              i_q_empty,
    input  wire t_frame_sum        i_q_head,
    output logic                   o_q_pop,
    output t_div_req               o_div_req,
    input  wire t_div_rsp          i_div_rsp,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_result                o_result
);

    t_back_state              r_state, n_state;
    t_frame_sum               r_frame, n_frame;
    logic                     r_present, n_present;
    logic signed [OFFX_W-1:0] r_ox, n_ox;
    logic signed [OFFY_W-1:0] r_oy, n_oy;
    logic [ANG_W-1:0]         r_ax, n_ax;
    logic [ANG_W-1:0]         r_ay, n_ay;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_out, n_out;

    logic signed [SUM_W+1:0]  w_ox_full;
    logic signed [SUM_W+1:0]  w_oy_full;
    logic signed [OFFX_W-1:0] w_ox_sat;
    logic signed [OFFY_W-1:0] w_oy_sat;
    logic [OFFX_W-1:0]        w_abs_ox;
    logic [OFFY_W-1:0]        w_abs_oy;

    function automatic logic [ANG_W-1:0] f_angle(
        input logic               neg,
        input logic               nonzero,
        input logic [DIST_W-1:0]  divisor,
        input logic [DIV_N_W-1:0] mag
    );
        logic [ANG_W:0] m_neg;
        m_neg = (ANG_W+1)'(0) - mag[ANG_W:0];
        if (divisor == '0) begin
            if (!nonzero) begin
                return '0;
            end
            return neg ? ANG_NEG_SAT : ANG_POS_SAT;
        end
        if (neg) begin
            return (mag > DIV_N_W'(ANG_NEG_SAT)) ? ANG_NEG_SAT : m_neg[ANG_W-1:0];
        end
        return (mag > DIV_N_W'(ANG_POS_SAT)) ? ANG_POS_SAT : mag[ANG_W-1:0];
    endfunction

    always_comb begin
        w_ox_full = $signed({2'b00, SUM_W'(HALF_W)}) - $signed({2'b00, i_div_rsp.quotient});
        w_oy_full = $signed({2'b00, SUM_W'(HALF_H)}) - $signed({2'b00, i_div_rsp.quotient});

        if (w_ox_full < $signed((SUM_W+2)'(OFFX_MIN))) begin
            w_ox_sat = OFFX_W'(OFFX_MIN);
        end else if (w_ox_full > $signed((SUM_W+2)'(OFFX_MAX))) begin
            w_ox_sat = OFFX_W'(OFFX_MAX);
        end else begin
            w_ox_sat = w_ox_full[OFFX_W-1:0];
        end

        if (w_oy_full < $signed((SUM_W+2)'(OFFY_MIN))) begin
            w_oy_sat = OFFY_W'(OFFY_MIN);
        end else if (w_oy_full > $signed((SUM_W+2)'(OFFY_MAX))) begin
            w_oy_sat = OFFY_W'(OFFY_MAX);
        end else begin
            w_oy_sat = w_oy_full[OFFY_W-1:0];
        end

        w_abs_ox = r_ox[OFFX_W-1] ? OFFX_W'(0) - r_ox : r_ox;
        w_abs_oy = r_oy[OFFY_W-1] ? OFFY_W'(0) - r_oy : r_oy;

        n_state     = r_state;
        n_frame     = r_frame;
        n_present   = r_present;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_q_pop     = 1'b0;
        o_div_req   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop            = 1'b1;
                    n_frame            = i_q_head;
                    n_present          = (i_q_head.count > CNT_W'(PRESENT_MIN));
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = i_q_head.sum_x;
                    o_div_req.divisor  = i_q_head.count;
                    n_state            = ST_QUO_X;
                end
            end
            ST_QUO_X: begin
                if (i_div_rsp.done) begin
                    n_ox               = r_present ? w_ox_sat : '0;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_frame.sum_y;
                    o_div_req.divisor  = r_frame.count;
                    n_state            = ST_QUO_Y;
                end
            end
            ST_QUO_Y: begin
                if (i_div_rsp.done) begin
                    n_oy               = r_present ? w_oy_sat : '0;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIV_N_W'({w_abs_ox, {ANG_SHIFT{1'b0}}});
                    o_div_req.divisor  = DIV_D_W'(i_x_distance);
                    n_state            = ST_ANG_X;
                end
            end
            ST_ANG_X: begin
                if (i_div_rsp.done) begin
                    n_ax = f_angle(r_ox[OFFX_W-1], r_ox != '0, i_x_distance,
                                   i_div_rsp.quotient);
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIV_N_W'({w_abs_oy, {ANG_SHIFT{1'b0}}});
                    o_div_req.divisor  = DIV_D_W'(i_y_distance);
                    n_state            = ST_ANG_Y;
                end
            end
            ST_ANG_Y: begin
                if (i_div_rsp.done) begin
                    n_ay = f_angle(r_oy[OFFY_W-1], r_oy != '0, i_y_distance,
                                   i_div_rsp.quotient);
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.present    = r_present;
                    n_out.offset_x   = r_ox;
                    n_out.offset_y   = r_oy;
                    n_out.angle_x    = r_ax;
                    n_out.angle_y    = r_ay;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_valid  = r_out_valid;
        o_result = r_out;
    end

    always_ff @(posedge i_clk) begin
        r_frame   <= n_frame;
        r_present <= n_present;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: design/chroma_threshold_centroid.sv
`default_nettype none
// Finds the centroid of chroma-matched macropixels in a YUY2 frame and reports its offset
// from the frame center plus a Q1.15 angle estimate. The input side takes one U/V
// macropixel per clock while not stalled: the accumulator counts matches and sums their
// coordinates, and on the request marked tlast it hands the frame totals to a two-entry
// queue and starts the next frame at once. The result side drains that queue through one
// shared radix-2 divider, doing four divides per frame (mean x, mean y, angle x, angle y),
// and each result then waits in an output register until taken. The input stalls only
// when two finished frames are still queued, i.e. when frames arrive faster than the
// result side can finish them or the result side is held off. Configuration writes take
// effect on the next clock; write them only while the block is idle.
module chroma_threshold_centroid import ctd_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // chroma_u, chroma_v
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // offset_x, offset_y, angle_x, angle_y
    output logic                        m_axis_tuser   // object_present
);

    logic [LIM_W-1:0]  r_u_limit;
    logic [LIM_W-1:0]  r_v_limit;
    logic [DIST_W-1:0] r_x_distance;
    logic [DIST_W-1:0] r_y_distance;

    logic       w_q_push;
    logic       w_q_pop;
    logic       w_q_full;
    logic       w_q_empty;
    t_frame_sum w_q_in;
    t_frame_sum w_q_head;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;
    t_result    w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_limit    <= U_LIMIT_RST;
            r_v_limit    <= V_LIMIT_RST;
            r_x_distance <= DIST_RST;
            r_y_distance <= DIST_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_U_LIMIT:    r_u_limit    <= i_cfg_data[LIM_W-1:0];
                CFG_V_LIMIT:    r_v_limit    <= i_cfg_data[LIM_W-1:0];
                CFG_X_DISTANCE: r_x_distance <= i_cfg_data[DIST_W-1:0];
                CFG_Y_DISTANCE: r_y_distance <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ctd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_u_limit    (r_u_limit),
        .i_v_limit    (r_v_limit),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_chroma_u   (s_axis_tdata[CHROMA_W-1:0]),
        .i_chroma_v   (s_axis_tdata[2*CHROMA_W-1:CHROMA_W]),
        .i_frame_last (s_axis_tlast),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_in)
    );

    ctd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_push_data (w_q_in),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_head      (w_q_head),
        .o_empty     (w_q_empty)
    );

    ctd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    ctd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_x_distance (r_x_distance),
        .i_y_distance (r_y_distance),
        .i_q_empty    (w_q_empty),
        .i_q_head     (w_q_head),
        .o_q_pop      (w_q_pop),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (w_result)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_result.angle_y, w_result.angle_x,
                                        w_result.offset_y, w_result.offset_x});
    assign m_axis_tuser = w_result.present;

endmodule
`default_nettype wire

FILE: design/ctd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ctd_checker import ctd_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    `CTD_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `CTD_ASSERT(a_absent_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "absent object with nonzero offsets")
    `CTD_ASSERT(a_angle_sign, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[9] || !m_axis_tdata[34]) && (m_axis_tdata[18] || !m_axis_tdata[50]), "angle sign disagrees with offset")
    `CTD_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind chroma_threshold_centroid ctd_checker u_ctd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
